// ----- rtl/core/hpa_pkg.sv -----
`default_nettype none

package hpa_pkg;

  localparam int FRAC_BITS = 16;

  // Saturation and lightness quotients stay below four times one.
  localparam int DIV_QW = FRAC_BITS + 2;
  localparam int DIV_XW = 17;
  localparam int DIV_DW = 16;

  localparam int HUE_QW = 6;

  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  localparam logic [FRAC_BITS:0] UNIT = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0] HALF_UNIT = (FRAC_BITS + 1)'(1) << (FRAC_BITS - 1);

  // Lightness is the product times one over 51000; since 51000 is eight times 6375,
  // this rounded-up reciprocal is exact for every product below 2^17.
  localparam int LIGHT_SHIFT = 30;
  localparam logic [FRAC_BITS+14:0] LIGHT_RECIP =
    (FRAC_BITS + 15)'(((64'd1 << (FRAC_BITS + LIGHT_SHIFT)) + 64'd50999) / 64'd51000);

  // Reciprocal of fifteen, exact for dividends below 2^(FRAC_BITS+4).
  localparam int RECIP_SHIFT = FRAC_BITS + 8;
  localparam logic [FRAC_BITS+4:0] RECIP15 =
    (FRAC_BITS + 5)'(((64'd1 << RECIP_SHIFT) + 64'd14) / 64'd15);

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 9;
  localparam logic [CFG_IW-1:0] REG_HUE_SHIFT = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SAT_ADJUST = 2'd1;
  localparam logic [CFG_IW-1:0] REG_LIGHT_ADJUST = 2'd2;

  typedef struct packed {
    logic [7:0] d;
    logic [8:0] sum;
    logic [7:0] den;
    logic [8:0] hue_base;
    logic       hue_neg;
    logic [7:0] hue_mag;
  } hpa_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/hpa_div.sv -----
`default_nettype none

module hpa_div (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [hpa_pkg::DIV_XW-1:0]        x,
  input  wire logic [hpa_pkg::DIV_DW-1:0]        den,
  output logic      [hpa_pkg::DIV_QW-1:0]        quo
);

  localparam int QW = hpa_pkg::DIV_QW;
  localparam int XW = hpa_pkg::DIV_XW;
  localparam int DW = hpa_pkg::DIV_DW;

  logic [DW-1:0] rem [QW];
  logic [QW-1:0] qq  [QW];
  logic [DW-1:0] dd  [QW];
  logic          x_lsb;

  always_ff @(posedge clk) begin
    if (en) begin
      x_lsb <= x[0];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] q_in;
    logic [DW-1:0] den_in;
    logic          bit_in;
    logic [DW:0]   sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = DW'(x[XW-1:2]);
      assign q_in   = '0;
      assign den_in = den;
      assign bit_in = x[1];
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign q_in   = qq[k-1];
      assign den_in = dd[k-1];
      assign bit_in = (k == 1) ? x_lsb : 1'b0;
    end

    assign sh = {rem_in, bit_in};
    assign ge = sh >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? DW'(sh - {1'b0, den_in}) : sh[DW-1:0];
        qq[k]  <= {q_in[QW-2:0], ge};
        dd[k]  <= den_in;
      end
    end
  end

  assign quo = qq[QW-1];

endmodule

`default_nettype wire

// ----- rtl/core/hpa_front.sv -----
`default_nettype none

module hpa_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_red,
  input  wire logic [7:0]         in_green,
  input  wire logic [7:0]         in_blue,
  input  wire logic               q_full,
  output logic                    push,
  output hpa_pkg::hpa_item_t      item
);

  hpa_pkg::hpa_item_t cls;
  logic               f_valid;
  logic [7:0]         mx;
  logic [7:0]         mn;
  logic [8:0]         sum;

  always_comb begin
    mx = in_red;
    mn = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx) mx = in_blue;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;
    sum = {1'b0, mx} + {1'b0, mn};

    cls.d   = mx - mn;
    cls.sum = sum;
    cls.den = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);

    if (mx == in_red) begin
      if (in_green >= in_blue) begin
        cls.hue_base = 9'd0;
        cls.hue_neg  = 1'b0;
        cls.hue_mag  = in_green - in_blue;
      end else begin
        cls.hue_base = 9'd360;
        cls.hue_neg  = 1'b1;
        cls.hue_mag  = in_blue - in_green;
      end
    end else if (mx == in_green) begin
      cls.hue_base = 9'd120;
      cls.hue_neg  = in_blue < in_red;
      cls.hue_mag  = (in_blue >= in_red) ? in_blue - in_red : in_red - in_blue;
    end else begin
      cls.hue_base = 9'd240;
      cls.hue_neg  = in_red < in_green;
      cls.hue_mag  = (in_red >= in_green) ? in_red - in_green : in_green - in_red;
    end
  end

  assign push     = f_valid && !q_full;
  assign in_stall = f_valid && q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!in_stall) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item <= cls;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hpa_queue.sv -----
`default_nettype none

module hpa_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire hpa_pkg::hpa_item_t din,
  input  wire logic               pop,
  output hpa_pkg::hpa_item_t      dout,
  output logic                    not_empty,
  output logic                    full
);

  localparam int AW = hpa_pkg::QAW;
  localparam int DEPTH = hpa_pkg::QDEPTH;

  hpa_pkg::hpa_item_t entry [DEPTH];
  logic [AW-1:0]      wr_ptr;
  logic [AW-1:0]      rd_ptr;
  logic [AW:0]        count;
  logic               do_push;
  logic               do_pop;

  assign not_empty = count != '0;
  assign full      = count == (AW + 1)'(DEPTH);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign dout      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hpa_back.sv -----
`default_nettype none

module hpa_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire hpa_pkg::hpa_item_t q_head,
  output logic                    q_pop,
  input  wire logic [8:0]         hue_shift,
  input  wire logic [7:0]         sat_adjust,
  input  wire logic [7:0]         light_adjust,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue
);

  localparam int F = hpa_pkg::FRAC_BITS;
  localparam int QW = hpa_pkg::DIV_QW;
  localparam int HQ = hpa_pkg::HUE_QW;
  localparam int XW = hpa_pkg::DIV_XW;
  localparam int DW = hpa_pkg::DIV_DW;

  typedef enum logic [2:0] {
    SEL_RAMP = 3'b001,
    SEL_Q    = 3'b010,
    SEL_P    = 3'b100
  } sel_t;

  typedef struct packed {
    logic          valid;
    logic [7:0]    hrem;
    logic [HQ-1:0] hq;
    logic [HQ-1:0] hx;
    logic [7:0]    hd;
    logic [8:0]    base;
    logic          neg;
    logic          hzero;
    logic          szero;
    logic          lzero;
    logic [QW-1:0] light;
  } side_t;

  logic adv;

  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && q_valid;

  // Preparation: products that feed the dividers.
  logic signed [8:0] sf;
  logic signed [8:0] lf;
  logic              p_valid;
  logic [XW-1:0]     p_sat_x;
  logic [DW-1:0]     p_sat_den;
  logic [XW-1:0]     p_light_x;
  logic              p_szero;
  logic              p_lzero;
  logic [13:0]       p_hx;
  logic [7:0]        p_hd;
  logic [8:0]        p_base;
  logic              p_neg;
  logic              p_hzero;

  assign sf = 9'sd100 + $signed({sat_adjust[7], sat_adjust});
  assign lf = 9'sd100 + $signed({light_adjust[7], light_adjust});

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_sat_x   <= XW'(16'(q_head.d) * 16'(sf[7:0]));
      p_sat_den <= DW'(16'(q_head.den) * 16'd100);
      p_light_x <= XW'(17'(q_head.sum) * 17'(lf[7:0]));
      p_szero   <= (q_head.d == 8'd0) || (sf <= 9'sd0);
      p_lzero   <= lf <= 9'sd0;
      p_hx      <= 14'(14'(q_head.hue_mag) * 14'd60);
      p_hd      <= q_head.d;
      p_base    <= q_head.hue_base;
      p_neg     <= q_head.hue_neg;
      p_hzero   <= q_head.d == 8'd0;
    end
  end

  logic [QW-1:0]      sat_q;
  logic [XW+F+14:0]   light_prod;

  assign light_prod = (XW + F + 15)'(p_light_x) * (XW + F + 15)'(hpa_pkg::LIGHT_RECIP);

  hpa_div u_sat_div (
    .clk (clk),
    .en  (adv),
    .x   (p_sat_x),
    .den (p_sat_den),
    .quo (sat_q)
  );

  // Side line alongside the saturation divider; the hue sector division runs in its
  // first stages and the lightness quotient rides along to stay aligned.
  side_t side [QW];

  for (genvar k = 0; k < QW; k++) begin : g_side
    side_t s_in;
    side_t s_nx;

    if (k == 0) begin : g_first
      assign s_in = '{valid: p_valid, hrem: p_hx[13:HQ], hq: '0, hx: p_hx[HQ-1:0],
                      hd: p_hd, base: p_base, neg: p_neg, hzero: p_hzero,
                      szero: p_szero, lzero: p_lzero,
                      light: light_prod[hpa_pkg::LIGHT_SHIFT+QW-1:hpa_pkg::LIGHT_SHIFT]};
    end else begin : g_next
      assign s_in = side[k-1];
    end

    if (k < HQ) begin : g_hue
      logic [8:0] sh;
      assign sh = {s_in.hrem, s_in.hx[HQ-1-k]};
      always_comb begin
        s_nx = s_in;
        if (sh >= {1'b0, s_in.hd}) begin
          s_nx.hrem = 8'(sh - {1'b0, s_in.hd});
          s_nx.hq   = {s_in.hq[HQ-2:0], 1'b1};
        end else begin
          s_nx.hrem = sh[7:0];
          s_nx.hq   = {s_in.hq[HQ-2:0], 1'b0};
        end
      end
    end else begin : g_carry
      assign s_nx = s_in;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side[k].valid <= 1'b0;
      end else if (adv) begin
        side[k] <= s_nx;
      end
    end
  end

  // Stage A: clamp saturation and lightness, finish the hue sector.
  side_t      s_end;
  logic [6:0] hue_step;
  logic       a_valid;
  logic [F:0] a_sat;
  logic [F:0] a_light;
  logic [8:0] a_hue;

  assign s_end    = side[QW-1];
  assign hue_step = 7'(s_end.hq) + 7'(s_end.neg && (s_end.hrem != 8'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= s_end.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s_end.szero) begin
        a_sat <= '0;
      end else if (sat_q > QW'(hpa_pkg::UNIT)) begin
        a_sat <= hpa_pkg::UNIT;
      end else begin
        a_sat <= sat_q[F:0];
      end
      if (s_end.lzero) begin
        a_light <= '0;
      end else if (s_end.light > QW'(hpa_pkg::UNIT)) begin
        a_light <= hpa_pkg::UNIT;
      end else begin
        a_light <= s_end.light[F:0];
      end
      if (s_end.hzero) begin
        a_hue <= 9'd0;
      end else if (s_end.neg) begin
        a_hue <= 9'(s_end.base - 9'(hue_step));
      end else begin
        a_hue <= 9'(s_end.base + 9'(hue_step));
      end
    end
  end

  // Stage B: lightness times saturation, hue offset.
  logic [2*F+1:0] ls_prod;
  logic [9:0]     hs_sum;
  logic           b_valid;
  logic [F:0]     b_sat;
  logic [F:0]     b_light;
  logic [F:0]     b_lsp;
  logic [8:0]     b_hue;

  assign ls_prod = (2*F + 2)'(a_light) * (2*F + 2)'(a_sat);
  assign hs_sum  = 10'(a_hue) + 10'(hue_shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sat   <= a_sat;
      b_light <= a_light;
      b_lsp   <= ls_prod[2*F:F];
      if (hs_sum >= 10'd720) begin
        b_hue <= 9'(hs_sum - 10'd720);
      end else if (hs_sum >= 10'd360) begin
        b_hue <= 9'(hs_sum - 10'd360);
      end else begin
        b_hue <= hs_sum[8:0];
      end
    end
  end

  // Stage C: q and p, channel angles.
  logic [F+2:0]        qsum;
  logic [F:0]          q_c;
  logic signed [F+3:0] pw;
  logic [F:0]          p_c;
  logic [9:0]          tr_sum;
  logic [9:0]          tb_sum;
  logic                c_valid;
  logic                c_gray;
  logic [F:0]          c_light;
  logic [F:0]          c_q;
  logic [F:0]          c_p;
  logic [8:0]          c_t [3];

  always_comb begin
    if (b_light < hpa_pkg::HALF_UNIT) begin
      qsum = {2'b0, b_light} + {2'b0, b_lsp};
    end else begin
      qsum = {2'b0, b_light} + {2'b0, b_sat} - {2'b0, b_lsp};
    end
    q_c = (qsum > {2'b0, hpa_pkg::UNIT}) ? hpa_pkg::UNIT : qsum[F:0];
    pw  = $signed({2'b0, b_light, 1'b0}) - $signed({3'b0, q_c});
    if (pw < 0) begin
      p_c = '0;
    end else if (pw > $signed({3'b0, hpa_pkg::UNIT})) begin
      p_c = hpa_pkg::UNIT;
    end else begin
      p_c = pw[F:0];
    end
    if (p_c > q_c) p_c = q_c;
    tr_sum = 10'(b_hue) + 10'd120;
    tb_sum = 10'(b_hue) + 10'd240;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_gray  <= b_sat == '0;
      c_light <= b_light;
      c_q     <= q_c;
      c_p     <= p_c;
      c_t[0]  <= (tr_sum >= 10'd360) ? 9'(tr_sum - 10'd360) : tr_sum[8:0];
      c_t[1]  <= b_hue;
      c_t[2]  <= (tb_sum >= 10'd360) ? 9'(tb_sum - 10'd360) : tb_sum[8:0];
    end
  end

  // Stage D: ramp selection and ramp product.
  sel_t         sel_c [3];
  logic [5:0]   ramp_u [3];
  logic         d_valid;
  logic         d_gray;
  logic [F:0]   d_light;
  logic [F:0]   d_q;
  logic [F:0]   d_p;
  sel_t         d_sel [3];
  logic [F+6:0] d_k [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (c_t[i] < 9'd60) begin
        sel_c[i]  = SEL_RAMP;
        ramp_u[i] = c_t[i][5:0];
      end else if (c_t[i] < 9'd180) begin
        sel_c[i]  = SEL_Q;
        ramp_u[i] = 6'd0;
      end else if (c_t[i] < 9'd240) begin
        sel_c[i]  = SEL_RAMP;
        ramp_u[i] = 6'(9'd240 - c_t[i]);
      end else begin
        sel_c[i]  = SEL_P;
        ramp_u[i] = 6'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_gray  <= c_gray;
      d_light <= c_light;
      d_q     <= c_q;
      d_p     <= c_p;
      for (int i = 0; i < 3; i++) begin
        d_sel[i] <= sel_c[i];
        d_k[i]   <= (F + 7)'(c_q - c_p) * (F + 7)'(ramp_u[i]);
      end
    end
  end

  // Stage E: divide the ramp product by sixty.
  logic         e_valid;
  logic         e_gray;
  logic [F:0]   e_light;
  logic [F:0]   e_q;
  logic [F:0]   e_p;
  sel_t         e_sel [3];
  logic [F:0]   e_quo [3];
  logic [2*F+8:0] recip_prod [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      recip_prod[i] = (2*F + 9)'(d_k[i][F+5:2]) * (2*F + 9)'(hpa_pkg::RECIP15);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_gray  <= d_gray;
      e_light <= d_light;
      e_q     <= d_q;
      e_p     <= d_p;
      for (int i = 0; i < 3; i++) begin
        e_sel[i] <= d_sel[i];
        e_quo[i] <= recip_prod[i][2*F+8:hpa_pkg::RECIP_SHIFT];
      end
    end
  end

  // Stage F: channel values.
  logic       f_valid;
  logic [F:0] f_v [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (e_gray) begin
          f_v[i] <= e_light;
        end else begin
          case (e_sel[i])
            SEL_RAMP: f_v[i] <= (F + 1)'(e_p + e_quo[i]);
            SEL_Q:    f_v[i] <= e_q;
            default:  f_v[i] <= e_p;
          endcase
        end
      end
    end
  end

  // Output register: round to eight bits.
  logic [F+8:0] scaled [3];
  logic [7:0]   o_byte [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      scaled[i] = ((F + 9)'(f_v[i]) << 8) - (F + 9)'(f_v[i]) + (F + 9)'(hpa_pkg::HALF_UNIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        o_byte[i] <= scaled[i][F+7:F];
      end
    end
  end

  assign out_red   = o_byte[0];
  assign out_green = o_byte[1];
  assign out_blue  = o_byte[2];

endmodule

`default_nettype wire

// ----- rtl/core/hsl_pixel_adjust_core.sv -----
`default_nettype none

// Channel   Handshake            Word
// in        in_valid/in_stall    in_red, in_green, in_blue (8 bits each)
// out       out_valid/out_stall  out_red, out_green, out_blue (8 bits each)
// cfg       cfg_we               cfg_index (2 bits), cfg_data (9 bits)
//
// One word is accepted per cycle and one result word leaves per cycle while no stall
// holds the flow; most of the back pipeline is the bit-per-stage saturation divider.
// Reset is synchronous; it empties the pipeline and clears the adjust registers.
// A stall at a valid output freezes the back pipeline; the four-word queue keeps the
// front accepting until it fills.

module hsl_pixel_adjust_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_red,
  input  wire logic [7:0]                      in_green,
  input  wire logic [7:0]                      in_blue,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           out_red,
  output logic [7:0]                           out_green,
  output logic [7:0]                           out_blue,
  input  wire logic                            cfg_we,
  input  wire logic [hpa_pkg::CFG_IW-1:0]      cfg_index,
  input  wire logic [hpa_pkg::CFG_DW-1:0]      cfg_data
);

  logic [8:0]         hue_shift;
  logic [7:0]         sat_adjust;
  logic [7:0]         light_adjust;
  logic               q_full;
  logic               push;
  hpa_pkg::hpa_item_t f_item;
  hpa_pkg::hpa_item_t q_head;
  logic               q_valid;
  logic               q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_shift    <= '0;
      sat_adjust   <= '0;
      light_adjust <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hpa_pkg::REG_HUE_SHIFT:    hue_shift    <= cfg_data;
        hpa_pkg::REG_SAT_ADJUST:   sat_adjust   <= cfg_data[7:0];
        hpa_pkg::REG_LIGHT_ADJUST: light_adjust <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  hpa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .q_full   (q_full),
    .push     (push),
    .item     (f_item)
  );

  hpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (f_item),
    .pop       (q_pop),
    .dout      (q_head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  hpa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .hue_shift    (hue_shift),
    .sat_adjust   (sat_adjust),
    .light_adjust (light_adjust),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

endmodule

`default_nettype wire

// ----- dv/hsl_pixel_adjust_core_tb.sv -----
module hsl_pixel_adjust_core_tb;

  localparam int ONE = 1 << hpa_pkg::FRAC_BITS;
  localparam int LATENCY = hpa_pkg::FRAC_BITS + 12;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct {
    pixel_t src;
    logic   known;
    pixel_t res;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_red, in_green, in_blue;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_red, out_green, out_blue;
  logic cfg_we;
  logic [hpa_pkg::CFG_IW-1:0] cfg_index;
  logic [hpa_pkg::CFG_DW-1:0] cfg_data;

  logic [8:0] hue_offset;
  logic signed [7:0] sat_pct;
  logic signed [7:0] light_pct;

  pixel_t pending_pixels[$];
  int errors;
  int cycles;
  logic sending;

  hsl_pixel_adjust_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint unit_clamp(longint v);
    if (v < 0) return 0;
    if (v > ONE) return ONE;
    return v;
  endfunction

  function automatic longint hue_sector(longint base, longint num, longint d);
    if (num >= 0) return base + (60 * num) / d;
    return base - (60 * (-num) + d - 1) / d;
  endfunction

  function automatic longint ramp(longint t, longint p, longint q);
    if (t < 60) return p + ((q - p) * t) / 60;
    if (t < 180) return q;
    if (t < 240) return p + ((q - p) * (240 - t)) / 60;
    return p;
  endfunction

  function automatic logic [7:0] to_byte(longint v);
    longint w;
    w = (v * 255 + ONE / 2) >>> hpa_pkg::FRAC_BITS;
    return w[7:0];
  endfunction

  function automatic pixel_t adjust_pixel(pixel_t px);
    longint r, g, b, mx, mn, d, sum, hue, sat, light, p, q, lsp, sf, lf, den;
    pixel_t res;
    r = px.red; g = px.green; b = px.blue;
    sf = 100 + longint'(sat_pct);
    lf = 100 + longint'(light_pct);
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    sum = mx + mn;
    if (d == 0) hue = 0;
    else if (mx == r) hue = (g >= b) ? hue_sector(0, g - b, d) : hue_sector(360, g - b, d);
    else if (mx == g) hue = hue_sector(120, b - r, d);
    else hue = hue_sector(240, r - g, d);
    hue = (hue + longint'(hue_offset)) % 360;
    if (d == 0 || sf <= 0) sat = 0;
    else begin
      den = (sum <= 255) ? sum : 510 - sum;
      sat = unit_clamp((d * sf * ONE) / (den * 100));
    end
    light = (lf <= 0) ? 0 : unit_clamp((sum * lf * ONE) / 51000);
    if (sat == 0) begin
      res.red = to_byte(light);
      res.green = res.red;
      res.blue = res.red;
      return res;
    end
    lsp = (light * sat) >>> hpa_pkg::FRAC_BITS;
    if (light < ONE / 2) q = light + lsp;
    else q = light + sat - lsp;
    q = unit_clamp(q);
    p = unit_clamp(2 * light - q);
    if (p > q) p = q;
    res.red = to_byte(ramp((hue + 120) % 360, p, q));
    res.green = to_byte(ramp(hue, p, q));
    res.blue = to_byte(ramp((hue + 240) % 360, p, q));
    return res;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("hsl_pixel_adjust_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected word: red %0d green %0d blue %0d", out_red, out_green, out_blue);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_red !== want.red) begin
          $error("out_red expected %0d actual %0d", want.red, out_red);
          errors++;
        end
        if (out_green !== want.green) begin
          $error("out_green expected %0d actual %0d", want.green, out_green);
          errors++;
        end
        if (out_blue !== want.blue) begin
          $error("out_blue expected %0d actual %0d", want.blue, out_blue);
          errors++;
        end
      end
    end
  end

  // The receiver draws a wait before taking each word.
  initial begin
    int gap;
    out_stall = 1;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (sending && $urandom_range(0, 4) == 0) gap = 0;
      if (gap > 0) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk iff out_valid);
    end
  end

  task automatic send_pixel(pixel_t px, logic busy_run);
    int gap;
    gap = busy_run ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_red <= px.red;
    in_green <= px.green;
    in_blue <= px.blue;
    pending_pixels.push_back(adjust_pixel(px));
    @(posedge clk iff !in_stall);
  endtask

  task automatic write_reg(logic [hpa_pkg::CFG_IW-1:0] idx, logic [hpa_pkg::CFG_DW-1:0] val);
    in_valid <= 0;
    wait (pending_pixels.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == hpa_pkg::REG_HUE_SHIFT) hue_offset = val;
    else if (idx == hpa_pkg::REG_SAT_ADJUST) sat_pct = val[7:0];
    else light_pct = val[7:0];
    @(posedge clk);
  endtask

  function automatic pixel_t pix(int r, int g, int b);
    pixel_t px;
    px.red = 8'(r); px.green = 8'(g); px.blue = 8'(b);
    return px;
  endfunction

  function automatic row_t row(pixel_t src, logic known, pixel_t res);
    row_t t;
    t.src = src; t.known = known; t.res = res;
    return t;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    int mode;
    mode = $urandom_range(0, 9);
    px = pix($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    if (mode == 0) px.green = px.red;
    if (mode == 1) begin
      px.green = px.red;
      px.blue = px.red;
    end
    if (mode == 2) px.blue = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
    return px;
  endfunction

  initial begin
    row_t rows[$];
    logic [8:0] hue_set[6];
    logic [7:0] pct_set[7];
    int phase;
    logic busy;
    hue_set = '{9'd0, 9'd359, 9'd360, 9'd120, 9'd1, 9'd511};
    pct_set = '{8'd0, 8'd100, 8'h9C, 8'd127, 8'h80, 8'd37, 8'hE7};
    errors = 0;
    cycles = 0;
    sending = 0;
    rst = 1;
    in_valid = 0;
    in_red = 0; in_green = 0; in_blue = 0;
    cfg_we = 0; cfg_index = hpa_pkg::REG_HUE_SHIFT; cfg_data = 0;
    hue_offset = 0; sat_pct = 0; light_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    rows.push_back(row(pix(0, 0, 0), 1, pix(0, 0, 0)));
    rows.push_back(row(pix(255, 255, 255), 1, pix(255, 255, 255)));
    rows.push_back(row(pix(128, 128, 128), 1, pix(128, 128, 128)));
    rows.push_back(row(pix(255, 0, 0), 1, pix(255, 0, 0)));
    rows.push_back(row(pix(0, 255, 0), 1, pix(0, 255, 0)));
    rows.push_back(row(pix(0, 0, 255), 1, pix(0, 0, 255)));
    rows.push_back(row(pix(255, 255, 0), 0, pix(0, 0, 0)));
    rows.push_back(row(pix(0, 255, 255), 0, pix(0, 0, 0)));
    rows.push_back(row(pix(255, 0, 255), 0, pix(0, 0, 0)));
    rows.push_back(row(pix(255, 0, 1), 0, pix(0, 0, 0)));
    rows.push_back(row(pix(200, 10, 100), 0, pix(0, 0, 0)));
    rows.push_back(row(pix(10, 200, 100), 0, pix(0, 0, 0)));
    rows.push_back(row(pix(100, 10, 200), 0, pix(0, 0, 0)));
    rows.push_back(row(pix(1, 0, 0), 0, pix(0, 0, 0)));
    rows.push_back(row(pix(254, 255, 255), 0, pix(0, 0, 0)));
    rows.push_back(row(pix(170, 85, 85), 0, pix(0, 0, 0)));
    foreach (rows[i]) begin
      send_pixel(rows[i].src, 0);
      if (rows[i].known && pending_pixels[$] != rows[i].res) begin
        $error("table row %0d disagrees with the adjustment", i);
        errors++;
      end
    end

    for (phase = 0; phase < 24; phase++) begin
      write_reg(hpa_pkg::REG_HUE_SHIFT, hue_set[$urandom_range(0, 5)]);
      write_reg(hpa_pkg::REG_SAT_ADJUST, {1'b0, pct_set[phase % 7]});
      write_reg(hpa_pkg::REG_LIGHT_ADJUST, {1'b0, pct_set[(phase * 3 + 1) % 7]});
      if (phase == 23) begin
        write_reg(hpa_pkg::REG_SAT_ADJUST, {1'b0, 8'($urandom_range(0, 255))});
      end
      busy = (phase % 4 == 1);
      sending = busy;
      send_pixel(pix(255, 0, 0), busy);
      send_pixel(pix(90, 90, 90), busy);
      repeat (60) send_pixel(rand_pixel(), busy);
      sending = 0;
    end

    in_valid <= 0;
    wait (pending_pixels.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("hsl_pixel_adjust_core: match");
    else $display("hsl_pixel_adjust_core: mismatch");
    $finish;
  end

endmodule
